### sv/lpfr_pkg.sv
// ---------------------------------------------------------------------------
// lpfr_pkg: shared types and constants of the frame receiver
// Command codes between the frame parser and the CRC/result engine, result
// item codes, and the byte-parallel CRC-16/XMODEM update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpfr_pkg;

   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [15:0] CRC_TOP        = 16'h8000;
   localparam logic [15:0] CRC_INIT       = 16'h0000;
   localparam logic [15:0] FRAME_OVERHEAD = 16'd5;

   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

   // Commands from the parser to the back end.
   typedef enum logic [2:0] {
      CMD_CRC_START,   // first length byte: restart CRC over this byte
      CMD_CRC_UPDATE,  // header byte: fold into CRC
      CMD_PAYLOAD,     // payload byte: fold into CRC and pass on
      CMD_CRC_HIGH,    // hold received CRC high byte
      CMD_CRC_CHECK,   // received CRC low byte: compare and report
      CMD_TOO_SHORT,   // length below five: report and drop frame
      CMD_TIMEOUT      // timeout inside a frame: report and drop frame
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
      logic [7:0]   data;
      logic [7:0]   frame_id;
      logic [15:0]  payload_length;
   } cmd_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  frame_id;
      logic [7:0]  payload_byte;
      logic [1:0]  status;
      logic [15:0] payload_length;
   } rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0] data);
      logic [15:0] r;
      r = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((r & CRC_TOP) != 16'h0000) begin
            r = (r << 1) ^ CRC_POLY;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

endpackage

### sv/lpfr_fifo.sv
// ---------------------------------------------------------------------------
// lpfr_fifo: small register FIFO
// Holds DEPTH words of WIDTH bits; the oldest word is shown while not empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/lpfr_front.sv
// ---------------------------------------------------------------------------
// lpfr_front: frame parser
// Tracks the frame layout and turns each received byte, and each timeout inside a
// frame, into a command for the CRC/result engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfr_front
   import lpfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       op,
   input  logic [7:0] rx_byte,
   output logic       cmd_push,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      PH_LEN_HI,
      PH_LEN_LO,
      PH_ID,
      PH_PAYLOAD,
      PH_CRC_HI,
      PH_CRC_LO
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] full_length;
   logic [15:0] remaining_dec;

   assign full_length   = {frame_length_ff[15:8], rx_byte};
   assign remaining_dec = remaining_ff - 16'd1;

   always_comb begin
      phase_in            = phase_ff;
      frame_length_in     = frame_length_ff;
      remaining_in        = remaining_ff;
      id_in               = id_ff;
      cmd_push            = 1'b0;
      cmd.code            = CMD_CRC_UPDATE;
      cmd.data            = rx_byte;
      cmd.frame_id        = id_ff;
      cmd.payload_length  = frame_length_ff - FRAME_OVERHEAD;
      if (accept && op == OP_TIMEOUT) begin
         // A timeout while waiting for a new frame is simply dropped.
         if (phase_ff != PH_LEN_HI) begin
            cmd_push = 1'b1;
            cmd.code = CMD_TIMEOUT;
            if (phase_ff == PH_LEN_LO || phase_ff == PH_ID) begin
               cmd.frame_id = 8'h00;
            end
            if (phase_ff == PH_LEN_LO || frame_length_ff < FRAME_OVERHEAD) begin
               cmd.payload_length = 16'h0000;
            end
         end
         phase_in = PH_LEN_HI;
      end else if (accept) begin
         cmd_push = 1'b1;
         unique case (phase_ff)
            PH_LEN_LO: begin
               frame_length_in = full_length;
               if (full_length < FRAME_OVERHEAD) begin
                  cmd.code           = CMD_TOO_SHORT;
                  cmd.frame_id       = 8'h00;
                  cmd.payload_length = 16'h0000;
                  phase_in           = PH_LEN_HI;
               end else begin
                  cmd.code     = CMD_CRC_UPDATE;
                  remaining_in = full_length - FRAME_OVERHEAD;
                  phase_in     = PH_ID;
               end
            end
            PH_ID: begin
               cmd.code = CMD_CRC_UPDATE;
               id_in    = rx_byte;
               phase_in = (remaining_ff != 16'h0000) ? PH_PAYLOAD : PH_CRC_HI;
            end
            PH_PAYLOAD: begin
               cmd.code     = CMD_PAYLOAD;
               remaining_in = remaining_dec;
               if (remaining_dec == 16'h0000) begin
                  phase_in = PH_CRC_HI;
               end
            end
            PH_CRC_HI: begin
               cmd.code = CMD_CRC_HIGH;
               phase_in = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               cmd.code = CMD_CRC_CHECK;
               phase_in = PH_LEN_HI;
            end
            default: begin
               cmd.code        = CMD_CRC_START;
               frame_length_in = {rx_byte, 8'h00};
               phase_in        = PH_LEN_LO;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LEN_HI;
         frame_length_ff <= 16'h0000;
         remaining_ff    <= 16'h0000;
         id_ff           <= 8'h00;
      end else begin
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         remaining_ff    <= remaining_in;
         id_ff           <= id_in;
      end
   end

endmodule

### sv/lpfr_back.sv
// ---------------------------------------------------------------------------
// lpfr_back: CRC and result engine
// Executes parser commands: keeps the running CRC, checks the received CRC
// and builds the result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpfr_back
   import lpfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic [15:0] crc_next;

   assign cmd_pop  = !cmd_empty && !rsp_full;
   assign crc_next = crc_byte(crc_ff, cmd.data);

   always_comb begin
      crc_in             = crc_ff;
      crc_high_in        = crc_high_ff;
      rsp_push           = 1'b0;
      rsp.kind           = KIND_STATUS;
      rsp.frame_id       = cmd.frame_id;
      rsp.payload_byte   = 8'h00;
      rsp.status         = STATUS_OK;
      rsp.payload_length = cmd.payload_length;
      if (cmd_pop) begin
         unique case (cmd.code)
            CMD_CRC_START: begin
               crc_in = crc_byte(CRC_INIT, cmd.data);
            end
            CMD_CRC_UPDATE: begin
               crc_in = crc_next;
            end
            CMD_PAYLOAD: begin
               crc_in             = crc_next;
               rsp_push           = 1'b1;
               rsp.kind           = KIND_PAYLOAD;
               rsp.payload_byte   = cmd.data;
               rsp.payload_length = 16'h0000;
            end
            CMD_CRC_HIGH: begin
               crc_high_in = cmd.data;
            end
            CMD_CRC_CHECK: begin
               crc_in     = CRC_INIT;
               rsp_push   = 1'b1;
               rsp.status = ({crc_high_ff, cmd.data} == crc_ff) ?
                            STATUS_OK : STATUS_CRC_BAD;
            end
            CMD_TOO_SHORT: begin
               crc_in     = CRC_INIT;
               rsp_push   = 1'b1;
               rsp.status = STATUS_TOO_SHORT;
            end
            CMD_TIMEOUT: begin
               crc_in     = CRC_INIT;
               rsp_push   = 1'b1;
               rsp.status = STATUS_TIMEOUT;
            end
            default: begin
               crc_in = crc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_INIT;
         crc_high_ff <= 8'h00;
      end else begin
         crc_ff      <= crc_in;
         crc_high_ff <= crc_high_in;
      end
   end

endmodule

### sv/length_prefixed_frame_receiver_crc16.sv
// A result reaches the rsp_ ports via the registered command and result queues.
// Throughput: one request per cycle while the command queue has room, set by
// the combinational parser step and the byte-parallel CRC update in the back end.
// Reset: synchronous active-high reset empties both queues, returns the parser
// to waiting for a length high byte and clears the CRC; no clearing pass.
// ---------------------------------------------------------------------------
// length_prefixed_frame_receiver_crc16: framed byte stream receiver
// Parses length/id/payload/CRC frames, passes payload bytes on tagged with
// the frame id and reports each frame's end with a CRC-16/XMODEM status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_receiver_crc16
   import lpfr_pkg::*;
#(
   parameter int CMD_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // Request side.
   input  logic        push,
   output logic        full,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   // Result side.
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_frame_id,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_payload_length
);

   // The parser sees each request as it is taken; it holds the frame layout
   // (phase, total length, remaining payload count, frame id) and emits one
   // command per request, except a timeout between frames, which is dropped.
   logic    accept;
   logic    cmd_push;
   cmd_type cmd_in_q;
   logic    cmd_full;
   logic    cmd_pop;
   cmd_type cmd_out_q;
   logic    cmd_empty;

   // The back end owns the running CRC and the received CRC high byte.
   logic    rsp_push;
   rsp_type rsp_in_q;
   logic    rsp_full;
   rsp_type rsp_out_q;

   // The request side stalls only when the command queue has no room.
   assign full   = cmd_full;
   assign accept = push && !cmd_full;

   lpfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op       (req_op),
      .rx_byte  (req_rx_byte),
      .cmd_push (cmd_push),
      .cmd      (cmd_in_q)
   );

   // Command queue between parser and back end lets each side stall alone.
   lpfr_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_q),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_q),
      .empty     (cmd_empty)
   );

   // The back end takes a command only when the result queue has room, so a
   // command that yields a result is never lost.
   lpfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_out_q),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in_q)
   );

   // Result queue: the oldest result sits on the rsp_ ports while not empty.
   lpfr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_q),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_out_q),
      .empty     (empty)
   );

   assign rsp_kind           = rsp_out_q.kind;
   assign rsp_frame_id       = rsp_out_q.frame_id;
   assign rsp_payload_byte   = rsp_out_q.payload_byte;
   assign rsp_status         = rsp_out_q.status;
   assign rsp_payload_length = rsp_out_q.payload_length;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the length-prefixed frame receiver
// Feeds framed byte streams and receive timeouts through the request queue,
// predicts every payload and status item with an independent frame parser,
// and compares each popped item field by field in arrival order.
// ---------------------------------------------------------------------------

module testbench;
   import lpfr_pkg::*;

   // Run-length controls. The limit is far above the slowest legal run.
   localparam int RANDOM_REQUESTS = 1400;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES    = 20;

   // Parser phases of the predictor, in wire order of a frame.
   typedef enum logic [2:0] {
      WAIT_LEN_HI,
      WAIT_LEN_LO,
      WAIT_ID,
      IN_PAYLOAD,
      WAIT_CRC_HI,
      WAIT_CRC_LO
   } rx_phase_type;

   // Where a directed row takes its byte from. CRC rows are filled in from
   // the predictor's running CRC when the row is sent.
   typedef enum logic [1:0] {
      SRC_DATA,
      SRC_CRC_HI,
      SRC_CRC_LO,
      SRC_BAD_CRC_LO
   } byte_src_type;

   typedef struct packed {
      logic         op;
      byte_src_type src;
      logic [7:0]   data;
      logic         typed;
      rsp_type      item;
   } stim_row_type;

   localparam rsp_type NO_ITEM = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        req_op = OP_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        pop = 1'b0;
   logic        full;
   logic        empty;
   logic        rsp_kind;
   logic [7:0]  rsp_frame_id;
   logic [7:0]  rsp_payload_byte;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_payload_length;

   // Predictor state: a private copy of the receiver's frame parser.
   rx_phase_type rx_phase = WAIT_LEN_HI;
   logic [15:0]  rx_crc = CRC_INIT;
   logic [15:0]  rx_length = 16'h0000;
   logic [15:0]  rx_remaining = 16'h0000;
   logic [7:0]   rx_id = 8'h00;
   logic [7:0]   rx_crc_high = 8'h00;

   // Items the receiver owes us, oldest first.
   rsp_type parsed_items_due[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  requests_taken = 0;
   bit  sender_burst = 1'b0;

   stim_row_type directed_rows [0:23];

   length_prefixed_frame_receiver_crc16 dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_op             (req_op),
      .req_rx_byte        (req_rx_byte),
      .empty              (empty),
      .pop                (pop),
      .rsp_kind           (rsp_kind),
      .rsp_frame_id       (rsp_frame_id),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_status         (rsp_status),
      .rsp_payload_length (rsp_payload_length)
   );

   always #1 clock = ~clock;

   // Watchdog: a hung handshake or a lost item ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d items pending", $time,
                  parsed_items_due.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // CRC-16/XMODEM, one message bit at a time, MSB first.
   function automatic logic [15:0] crc16_xmodem_next(input logic [15:0] crc,
                                                     input logic [7:0] data);
      logic [15:0] c;
      logic        feedback;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = c[15] ^ data[i];
         c = {c[14:0], 1'b0} ^ (feedback ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // One step of the frame parser for an accepted request. At most one item
   // comes out: a payload byte, or a status item at the end of a frame.
   task automatic parse_frame_byte(input logic op, input logic [7:0] data,
                                   output bit produced, output rsp_type item);
      produced = 1'b0;
      item = NO_ITEM;
      if (op == OP_TIMEOUT) begin
         // A timeout while idle is simply dropped.
         if (rx_phase != WAIT_LEN_HI) begin
            produced = 1'b1;
            item.kind = KIND_STATUS;
            item.status = STATUS_TIMEOUT;
            if (rx_phase >= IN_PAYLOAD) item.frame_id = rx_id;
            if (rx_phase >= WAIT_ID && rx_length >= FRAME_OVERHEAD) begin
               item.payload_length = rx_length - FRAME_OVERHEAD;
            end
            rx_phase = WAIT_LEN_HI;
            rx_crc = CRC_INIT;
         end
      end else begin
         case (rx_phase)
            WAIT_LEN_HI: begin
               rx_crc = crc16_xmodem_next(CRC_INIT, data);
               rx_length = {data, 8'h00};
               rx_phase = WAIT_LEN_LO;
            end
            WAIT_LEN_LO: begin
               rx_crc = crc16_xmodem_next(rx_crc, data);
               rx_length = {rx_length[15:8], data};
               if (rx_length < FRAME_OVERHEAD) begin
                  // Too short to hold even the header and CRC: drop it.
                  produced = 1'b1;
                  item.kind = KIND_STATUS;
                  item.status = STATUS_TOO_SHORT;
                  rx_phase = WAIT_LEN_HI;
                  rx_crc = CRC_INIT;
               end else begin
                  rx_remaining = rx_length - FRAME_OVERHEAD;
                  rx_phase = WAIT_ID;
               end
            end
            WAIT_ID: begin
               rx_crc = crc16_xmodem_next(rx_crc, data);
               rx_id = data;
               // An empty payload goes straight to the CRC bytes.
               rx_phase = (rx_remaining != 16'h0000) ? IN_PAYLOAD : WAIT_CRC_HI;
            end
            IN_PAYLOAD: begin
               rx_crc = crc16_xmodem_next(rx_crc, data);
               if (rx_remaining != 16'h0000) rx_remaining = rx_remaining - 16'd1;
               if (rx_remaining == 16'h0000) rx_phase = WAIT_CRC_HI;
               produced = 1'b1;
               item.kind = KIND_PAYLOAD;
               item.frame_id = rx_id;
               item.payload_byte = data;
            end
            WAIT_CRC_HI: begin
               rx_crc_high = data;
               rx_phase = WAIT_CRC_LO;
            end
            default: begin
               produced = 1'b1;
               item.kind = KIND_STATUS;
               item.frame_id = rx_id;
               item.status = ({rx_crc_high, data} == rx_crc) ? STATUS_OK
                                                              : STATUS_CRC_BAD;
               item.payload_length = rx_length - FRAME_OVERHEAD;
               rx_phase = WAIT_LEN_HI;
               rx_crc = CRC_INIT;
            end
         endcase
      end
   endtask

   // Sender idle time after a request. push is lowered only when a gap is
   // taken, so a back-to-back request keeps it high without a glitch.
   task automatic idle_sender();
      int n;
      n = sender_burst ? 0 : pick_gap();
      if (n > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Present one request, wait for the queue to take it, then record what
   // the receiver must produce for it. A typed row overrides the predictor's
   // item, but the predictor still steps so its state stays in line.
   task automatic send_request(input logic op, input logic [7:0] data,
                               input bit typed, input rsp_type typed_item);
      bit      produced;
      rsp_type item;
      @(negedge clock);
      push <= 1'b1;
      req_op <= op;
      req_rx_byte <= data;
      @(posedge clock);
      while (full) @(posedge clock);
      if (!(op == OP_TIMEOUT && rx_phase == WAIT_LEN_HI)) requests_taken++;
      parse_frame_byte(op, data, produced, item);
      if (typed) parsed_items_due.push_back(typed_item);
      else if (produced) parsed_items_due.push_back(item);
      idle_sender();
   endtask

   // One random frame-level sequence. Most are well-formed frames with random
   // content; the rest are short lengths, truncated frames, bad CRCs and
   // stray timeouts.
   task automatic send_random_frame();
      int          roll;
      int          plen;
      int          abort_at;
      int          corrupt;
      int          extra;
      bit          aborted;
      logic [15:0] total;
      logic [7:0]  id_byte;
      logic [7:0]  b;
      roll = $urandom_range(0, 99);
      sender_burst = ($urandom_range(0, 4) == 0);
      if (roll < 5) begin
         // Timeout with no frame open: ignored by the receiver.
         send_request(OP_TIMEOUT, 8'($urandom), 1'b0, NO_ITEM);
      end else if (roll < 13) begin
         send_request(OP_BYTE, 8'h00, 1'b0, NO_ITEM);
         send_request(OP_BYTE, 8'($urandom_range(0, 4)), 1'b0, NO_ITEM);
      end else if (roll < 21) begin
         // Random total length, a few bytes, then the link goes quiet.
         extra = $urandom_range(0, 6);
         send_request(OP_BYTE, 8'($urandom), 1'b0, NO_ITEM);
         send_request(OP_BYTE, 8'($urandom), 1'b0, NO_ITEM);
         repeat (extra) send_request(OP_BYTE, 8'($urandom), 1'b0, NO_ITEM);
         send_request(OP_TIMEOUT, 8'($urandom), 1'b0, NO_ITEM);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 85) plen = $urandom_range(0, 12);
         else if (roll < 98) plen = $urandom_range(13, 64);
         else plen = $urandom_range(65, 300);
         total = 16'(plen + 5);
         id_byte = 8'($urandom);
         abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, plen + 4) : 0;
         corrupt = $urandom_range(0, 99);
         aborted = 1'b0;
         for (int k = 0; k <= plen + 4 && !aborted; k++) begin
            if (k == abort_at && k > 0) begin
               send_request(OP_TIMEOUT, 8'($urandom), 1'b0, NO_ITEM);
               aborted = 1'b1;
            end else begin
               if (k == 0) b = total[15:8];
               else if (k == 1) b = total[7:0];
               else if (k == 2) b = id_byte;
               else if (k < plen + 3) b = 8'($urandom);
               else if (k == plen + 3) begin
                  b = rx_crc[15:8];
                  if (corrupt < 8) b = b ^ 8'($urandom_range(1, 255));
               end else begin
                  b = rx_crc[7:0];
                  if (corrupt >= 8 && corrupt < 16) b = b ^ 8'($urandom_range(1, 255));
               end
               send_request(OP_BYTE, b, 1'b0, NO_ITEM);
            end
         end
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field,
                  want, got);
         error_count++;
      end
   endtask

   // Result checker. Outputs are sampled at the rising edge, where a pop is
   // taken when the queue is not empty.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (parsed_items_due.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual kind %0d id 0x%0h",
                     $time, rsp_kind, rsp_frame_id);
            error_count++;
         end else begin
            want = parsed_items_due.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_kind));
            check_field("frame_id", 16'(want.frame_id), 16'(rsp_frame_id));
            check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_payload_byte));
            check_field("status", 16'(want.status), 16'(rsp_status));
            check_field("payload_length", want.payload_length, rsp_payload_length);
         end
      end
   end

   // Result side back-pressure: runs of pops broken by stalls. Long runs give
   // stretches in which the receiver never stalls.
   initial begin : result_drain
      int run;
      int stall;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                           : $urandom_range(1, 8);
         stall = pick_gap();
         repeat (run) begin
            @(negedge clock);
            pop <= 1'b1;
         end
         repeat (stall) begin
            @(negedge clock);
            pop <= 1'b0;
         end
      end
   end

   // Main sequence: reset, directed table, random frames, drain, verdict.
   initial begin : stimulus
      stim_row_type row;
      logic [7:0]   b;

      // Directed rows. Expected items are typed in where they are obvious:
      // short-length errors, timeouts, an empty frame and a one-byte frame
      // with a broken CRC. Untyped rows fall back on the predictor.
      directed_rows = '{
         // Timeout while idle: nothing comes out.
         '{OP_TIMEOUT, SRC_DATA, 8'h00, 1'b0, NO_ITEM},
         // Total length four is below the minimum.
         '{OP_BYTE, SRC_DATA, 8'h00, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'h04, 1'b1,
           '{KIND_STATUS, 8'h00, 8'h00, STATUS_TOO_SHORT, 16'd0}},
         // Empty payload with a correct CRC.
         '{OP_BYTE, SRC_DATA, 8'h00, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'h05, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'hFF, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_CRC_HI, 8'h00, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_CRC_LO, 8'h00, 1'b1,
           '{KIND_STATUS, 8'hFF, 8'h00, STATUS_OK, 16'd0}},
         // One payload byte, CRC low byte damaged.
         '{OP_BYTE, SRC_DATA, 8'h00, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'h06, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'hA5, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'h00, 1'b1,
           '{KIND_PAYLOAD, 8'hA5, 8'h00, STATUS_OK, 16'd0}},
         '{OP_BYTE, SRC_CRC_HI, 8'h00, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_BAD_CRC_LO, 8'h00, 1'b1,
           '{KIND_STATUS, 8'hA5, 8'h00, STATUS_CRC_BAD, 16'd1}},
         // Timeout after the high length byte only.
         '{OP_BYTE, SRC_DATA, 8'h12, 1'b0, NO_ITEM},
         '{OP_TIMEOUT, SRC_DATA, 8'hFF, 1'b1,
           '{KIND_STATUS, 8'h00, 8'h00, STATUS_TIMEOUT, 16'd0}},
         // Largest length, then a timeout before the id byte.
         '{OP_BYTE, SRC_DATA, 8'hFF, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'hFF, 1'b0, NO_ITEM},
         '{OP_TIMEOUT, SRC_DATA, 8'h00, 1'b1,
           '{KIND_STATUS, 8'h00, 8'h00, STATUS_TIMEOUT, 16'd65530}},
         // Timeout in the middle of a payload.
         '{OP_BYTE, SRC_DATA, 8'h00, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'h08, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'h3C, 1'b0, NO_ITEM},
         '{OP_BYTE, SRC_DATA, 8'hFF, 1'b1,
           '{KIND_PAYLOAD, 8'h3C, 8'hFF, STATUS_OK, 16'd0}},
         '{OP_TIMEOUT, SRC_DATA, 8'hAA, 1'b1,
           '{KIND_STATUS, 8'h3C, 8'h00, STATUS_TIMEOUT, 16'd3}}
      };

      // Reset is held from time zero and released on a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.src)
            SRC_CRC_HI: b = rx_crc[15:8];
            SRC_CRC_LO: b = rx_crc[7:0];
            SRC_BAD_CRC_LO: b = ~rx_crc[7:0];
            default: b = row.data;
         endcase
         send_request(row.op, b, row.typed, row.item);
      end

      requests_taken = 0;
      while (requests_taken < RANDOM_REQUESTS) send_random_frame();

      @(negedge clock);
      push <= 1'b0;

      // Wait for every owed item, then a little longer so that a stray
      // extra item would still be caught by the checker.
      while (parsed_items_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
sv/lpfr_pkg.sv
sv/lpfr_fifo.sv
sv/lpfr_front.sv
sv/lpfr_back.sv
sv/length_prefixed_frame_receiver_crc16.sv
bench/testbench.sv
